[hdl/cdv_pkg.sv]
// ----------------------------------------------------------------------------
// cdv_pkg: shared types and constants
// Result widths and the tag that travels with each pixel down the pipeline.
// ----------------------------------------------------------------------------
package cdv_pkg;

  localparam int SUM_W   = 40;   // width of the exact convolution sum
  localparam int POS_OUT = 8;    // width of the reported row and column
  localparam int CFG_IDX_W = 2;  // configuration register index width
  localparam int CFG_DAT_W = 9;  // widest configuration register

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE = 2'd1;

  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_PIXEL  = 1'b1;

  // Per-pixel bookkeeping carried alongside the arithmetic.
  typedef struct packed {
    logic               emit;
    logic               last;
    logic [POS_OUT-1:0] orow;
    logic [POS_OUT-1:0] ocol;
  } cdv_tag_t;

endpackage

[hdl/cdv_if.sv]
// ----------------------------------------------------------------------------
// cdv_if: stream interfaces
// Valid/ready channels for input items and convolution results.
// ----------------------------------------------------------------------------
interface cdv_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [4:0]                    weight_index;
  logic signed [SAMPLE_BITS-1:0] data_value;

  modport source (output valid, func, weight_index, data_value, input ready);
  modport sink   (input valid, func, weight_index, data_value, output ready);
endinterface

interface cdv_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] conv_sum;
  logic [7:0]         out_row;
  logic [7:0]         out_col;
  logic               last;

  modport source (output valid, conv_sum, out_row, out_col, last, input ready);
  modport sink   (input valid, conv_sum, out_row, out_col, last, output ready);
endinterface

[hdl/cdv_line_buf.sv]
// ----------------------------------------------------------------------------
// cdv_line_buf: line buffer memory
// One word per image column holding the previous rows of that column.
// ----------------------------------------------------------------------------
module cdv_line_buf #(
  parameter int WORD_W = 64,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/cdv_col_cell.sv]
// ----------------------------------------------------------------------------
// cdv_col_cell: window column cell
// Holds one window column, passes it to its left neighbor on each pixel,
// and forms the registered dot product with its weight column.
// ----------------------------------------------------------------------------
module cdv_col_cell
  import cdv_pkg::*;
#(
  parameter int KERNEL_MAX  = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    shift,
  input  logic                                    en,
  input  logic [KERNEL_MAX-1:0][SAMPLE_BITS-1:0]  col_in,
  input  logic [KERNEL_MAX-1:0][SAMPLE_BITS-1:0]  wcol,
  output logic [KERNEL_MAX-1:0][SAMPLE_BITS-1:0]  col_out,
  output logic signed [SUM_W-1:0]                 sum
);

  logic [KERNEL_MAX-1:0][SAMPLE_BITS-1:0] col_r;
  logic signed [SUM_W-1:0]                prod_r [KERNEL_MAX];
  logic signed [SUM_W-1:0]                prod_nxt [KERNEL_MAX];
  logic signed [SUM_W-1:0]                sum_r;
  logic signed [SUM_W-1:0]                sum_nxt;
  logic signed [2*SAMPLE_BITS-1:0]        p;

  always_comb begin
    sum_nxt = '0;
    p = '0;
    for (int i = 0; i < KERNEL_MAX; i++) begin
      // A zero weight gives a zero product even when the window slot holds
      // a line buffer word that was never loaded.
      if (wcol[i] == '0) begin
        p = '0;
      end else begin
        p = signed'(col_r[i]) * signed'(wcol[i]);
      end
      prod_nxt[i] = SUM_W'(p);
      sum_nxt = sum_nxt + prod_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift) begin
      col_r <= col_in;
    end
    if (en) begin
      for (int i = 0; i < KERNEL_MAX; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
      sum_r <= sum_nxt;
    end
  end

  assign col_out = col_r;
  assign sum     = sum_r;

endmodule

[hdl/conv2d_valid_stream_top.sv]
// ----------------------------------------------------------------------------
// conv2d_valid_stream_top: streaming valid 2D convolution
// Kernel weights and raster-order pixels arrive on one stream; each pixel
// that completes a window yields the exact sum of products.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Contents
//   in_ch     input      valid/ready    func, weight_index, data_value
//   out_ch    output     valid/ready    conv_sum, out_row, out_col, last
//   cfg_*     input      write enable   register index and data, no read-back
//
// One transaction is accepted per cycle while the pipeline is not held. The
// rate is set by the line buffer, which is read and written once per pixel,
// and by the column cells, which shift once per pixel.
// Reset is synchronous and active low; it clears the weights, the window,
// the position counters and the pipeline valid bits. When the output register
// is full and not taken, the whole pipeline holds and in_ch.ready drops.
// ----------------------------------------------------------------------------
module conv2d_valid_stream_top
  import cdv_pkg::*;
#(
  parameter int KERNEL_MAX  = 5,
  parameter int IMAGE_MAX   = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  cdv_in_if.sink               in_ch,
  cdv_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int POS_W  = $clog2(IMAGE_MAX);
  localparam int NW     = POS_W + 1;
  localparam int LROWS  = (KERNEL_MAX > 1) ? KERNEL_MAX - 1 : 1;
  localparam int LW     = LROWS * SAMPLE_BITS;
  localparam int WIN    = KERNEL_MAX * KERNEL_MAX;
  localparam int SB     = SAMPLE_BITS;

  typedef logic [SB-1:0] samp_t;

  // Configuration registers.
  logic [8:0] img_size_r;
  logic [2:0] ker_size_r;

  // Effective sizes after clamping to the supported range.
  logic [NW-1:0] n_eff;
  logic [2:0]    k_eff;
  logic [2:0]    off;

  // Pipeline control. The whole pipe advances together whenever the output
  // register can take a new value.
  logic en;
  logic acc;
  logic acc_pix;

  // Position of the next pixel.
  logic [POS_W-1:0] row_r, row_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] c_use;
  cdv_tag_t         tag0;

  // Kernel weights and the per-cell weight columns, already aligned to the
  // bottom-right corner of the window for the kernel size in use.
  samp_t                           kw_r   [WIN];
  logic [KERNEL_MAX-1:0][SB-1:0]   wsel_r [KERNEL_MAX];
  logic [KERNEL_MAX-1:0][SB-1:0]   wsel_nxt [KERNEL_MAX];

  // Stage 1: pixel waiting for its line buffer word.
  logic             s1_vld_r;
  samp_t            s1_val_r;
  logic [POS_W-1:0] s1_c_r;
  cdv_tag_t         s1_tag_r;
  logic             s1_fwd_r;
  logic [LW-1:0]    s1_fwdw_r;
  logic [LW-1:0]    lb_rd;
  logic [LW-1:0]    old_word;
  logic [LW-1:0]    new_word;
  logic [KERNEL_MAX-1:0][SB-1:0] colv;

  // Later stages only need the tag; emit acts as their valid bit.
  cdv_tag_t s2_tag_r, s3_tag_r, s4_tag_r;

  // Column cell chain.
  logic [KERNEL_MAX-1:0][SB-1:0] cell_in  [KERNEL_MAX];
  logic [KERNEL_MAX-1:0][SB-1:0] cell_out [KERNEL_MAX];
  logic signed [SUM_W-1:0]       cell_sum [KERNEL_MAX];
  logic signed [SUM_W-1:0]       total;

  // Output register.
  logic                    out_valid_r;
  logic signed [SUM_W-1:0] out_sum_r;
  cdv_tag_t                out_tag_r;

  // --------------------------------------------------------------------------
  // Effective sizes.
  // --------------------------------------------------------------------------
  always_comb begin
    if (img_size_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(img_size_r) > IMAGE_MAX) begin
      n_eff = NW'(IMAGE_MAX);
    end else begin
      n_eff = NW'(img_size_r);
    end
    if (ker_size_r == '0) begin
      k_eff = 3'd1;
    end else if (int'(ker_size_r) > KERNEL_MAX) begin
      k_eff = 3'(KERNEL_MAX);
    end else begin
      k_eff = ker_size_r;
    end
    off = 3'(KERNEL_MAX) - k_eff;
  end

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign acc          = in_ch.valid && en;
  assign acc_pix      = acc && (in_ch.func == FUNC_PIXEL);

  // --------------------------------------------------------------------------
  // Position tracking and per-pixel tag.
  // --------------------------------------------------------------------------
  always_comb begin
    if (NW'(col_r) >= n_eff) begin
      c_use = POS_W'(n_eff - NW'(1));
    end else begin
      c_use = col_r;
    end
    tag0.emit = (int'(row_r) + 1 >= int'(k_eff)) && (int'(c_use) + 1 >= int'(k_eff));
    tag0.last = (NW'(row_r) + NW'(1) == n_eff) && (NW'(c_use) + NW'(1) == n_eff);
    tag0.orow = POS_OUT'(int'(row_r) - int'(k_eff) + 1);
    tag0.ocol = POS_OUT'(int'(c_use) - int'(k_eff) + 1);
    if (NW'(c_use) + NW'(1) >= n_eff) begin
      col_nxt = '0;
      row_nxt = (NW'(row_r) + NW'(1) >= n_eff) ? '0 : row_r + POS_W'(1);
    end else begin
      col_nxt = c_use + POS_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_size_r <= 9'd8;
      ker_size_r <= 3'd3;
      row_r      <= '0;
      col_r      <= '0;
    end else if (cfg_we) begin
      // A write to either configuration register restarts the frame.
      if (cfg_addr == REG_IMAGE_SIZE) begin
        img_size_r <= cfg_data;
      end
      if (cfg_addr == REG_KERNEL_SIZE) begin
        ker_size_r <= cfg_data[2:0];
      end
      if (cfg_addr == REG_IMAGE_SIZE || cfg_addr == REG_KERNEL_SIZE) begin
        row_r <= '0;
        col_r <= '0;
      end
    end else if (acc_pix) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Kernel weights. Indices beyond the kernel storage are dropped.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN; i++) begin
        kw_r[i] <= '0;
      end
    end else if (acc && in_ch.func == FUNC_WEIGHT && int'(in_ch.weight_index) < WIN) begin
      for (int i = 0; i < WIN; i++) begin
        if (int'(in_ch.weight_index) == i) begin
          kw_r[i] <= in_ch.data_value;
        end
      end
    end
  end

  // Window position (ri, cj) uses weight (ri-off, cj-off); positions above or
  // left of the active kernel get zero. Refreshed only when the pipe advances,
  // so a weight written before a pixel is in place when that pixel's products
  // form, and a weight written after it never reaches them, even across a
  // stall.
  always_comb begin
    for (int j = 0; j < KERNEL_MAX; j++) begin
      for (int i = 0; i < KERNEL_MAX; i++) begin
        if (i >= int'(off) && j >= int'(off)) begin
          wsel_nxt[j][i] = kw_r[(i - int'(off)) * KERNEL_MAX + (j - int'(off))];
        end else begin
          wsel_nxt[j][i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < KERNEL_MAX; j++) begin
        wsel_r[j] <= wsel_nxt[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line buffer access. The word read for a column is shifted down by
  // one row and the new pixel goes on top. When the pixel just behind reads
  // the same column at the edge this write lands, the new word is forwarded.
  // --------------------------------------------------------------------------
  cdv_line_buf #(
    .WORD_W (LW),
    .DEPTH  (IMAGE_MAX),
    .ADDR_W (POS_W)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (acc_pix),
    .rd_addr (c_use),
    .rd_data (lb_rd),
    .wr_en   (s1_vld_r),
    .wr_addr (s1_c_r),
    .wr_data (new_word)
  );

  always_comb begin
    old_word = s1_fwd_r ? s1_fwdw_r : lb_rd;
    new_word = old_word;
    new_word[SB-1:0] = s1_val_r;
    for (int i = 1; i < LROWS; i++) begin
      new_word[i*SB +: SB] = old_word[(i-1)*SB +: SB];
    end
    // Oldest row at index 0, newest pixel at the bottom.
    colv = '0;
    colv[KERNEL_MAX-1] = s1_val_r;
    for (int i = 0; i + 1 < KERNEL_MAX; i++) begin
      colv[KERNEL_MAX-2-i] = old_word[i*SB +: SB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
      s4_tag_r <= '0;
    end else if (en) begin
      s1_vld_r <= acc_pix;
      s2_tag_r <= s1_vld_r ? s1_tag_r : '0;
      s3_tag_r <= s2_tag_r;
      s4_tag_r <= s3_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_pix) begin
      s1_val_r  <= in_ch.data_value;
      s1_c_r    <= c_use;
      s1_tag_r  <= tag0;
      s1_fwd_r  <= s1_vld_r && (s1_c_r == c_use);
      s1_fwdw_r <= new_word;
    end
  end

  // --------------------------------------------------------------------------
  // Window: a chain of column cells. The newest column enters at the right
  // and each cell hands its column to its left neighbor per pixel.
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < KERNEL_MAX; j++) begin : g_cell
    if (j == KERNEL_MAX - 1) begin : g_head
      assign cell_in[j] = colv;
    end else begin : g_link
      assign cell_in[j] = cell_out[j+1];
    end

    cdv_col_cell #(
      .KERNEL_MAX  (KERNEL_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (en && s1_vld_r),
      .en      (en),
      .col_in  (cell_in[j]),
      .wcol    (wsel_r[j]),
      .col_out (cell_out[j]),
      .sum     (cell_sum[j])
    );
  end

  always_comb begin
    total = '0;
    for (int j = 0; j < KERNEL_MAX; j++) begin
      total = total + cell_sum[j];
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s4_tag_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sum_r <= total;
      out_tag_r <= s4_tag_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.conv_sum = out_sum_r;
  assign out_ch.out_row  = out_tag_r.orow;
  assign out_ch.out_col  = out_tag_r.ocol;
  assign out_ch.last     = out_tag_r.last;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The frame always ends on the diagonal of the square output.
  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tag_r.last |-> out_tag_r.orow == out_tag_r.ocol)
    else $error("last result off the diagonal");

  // A register write restarts the frame at the top-left pixel.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_addr == REG_IMAGE_SIZE || cfg_addr == REG_KERNEL_SIZE)
    |=> row_r == '0 && col_r == '0)
    else $error("frame position not restarted by register write");

  // A stalled output freezes the pipe: the stage 1 valid bit and the stage 4 tag hold.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(s1_vld_r) && $stable(s4_tag_r))
    else $error("pipeline moved during output stall");

endmodule
